>>> sv/mld_pkg.sv
// mld_pkg: shared constants, types and the CORDIC arctangent table
// for the mouse look direction unit. No dependencies.
package mld_pkg;

  localparam int PITCH_LIMIT  = 11392;
  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int ONE_Q14      = 16384;
  localparam int POS_MAX      = 8388607;
  localparam int POS_MIN      = -8388608;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IW    = 5;

  localparam logic [2:0] REG_SENS = 3'd0;
  localparam logic [2:0] REG_FREE = 3'd1;
  localparam logic [2:0] REG_POSX = 3'd2;
  localparam logic [2:0] REG_POSY = 3'd3;
  localparam logic [2:0] REG_POSZ = 3'd4;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [15:0] ang_t;

  typedef struct packed {
    logic start;
    ang_t angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    q30_t c;
    q30_t s;
  } cordic_rsp_t;

  function automatic logic signed [25:0] atan_deg(input logic [ATAN_IW-1:0] i);
    logic signed [25:0] v;
    unique case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/mld_mul.sv
// mld_mul: shared 32x32 signed multiplier with registered product.
// Depends on mld_pkg.
module mld_mul (
  input  logic               clk,
  input  mld_pkg::q30_t      a,
  input  mld_pkg::q30_t      b,
  output logic signed [63:0] p_r
);
  import mld_pkg::*;

  logic signed [63:0] p_nxt;

  assign p_nxt = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule

>>> sv/mld_cordic.sv
// mld_cordic: rotation-mode CORDIC, one micro-rotation per cycle.
// Angle in Q9.7 degrees, cosine and sine in Q2.30. Depends on mld_pkg.
module mld_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mld_pkg::cordic_req_t      req,
  output mld_pkg::cordic_rsp_t      rsp
);
  import mld_pkg::*;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [ATAN_IW-1:0]         i_r, i_nxt;
  q30_t                       x_r, x_nxt, y_r, y_nxt;
  logic signed [25:0]         z_r, z_nxt;
  q30_t                       dx, dy;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      i_nxt    = '0;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = {{1{req.angle[15]}}, req.angle, 9'd0};
    end else if (busy_r) begin
      if (!z_r[25]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_deg(i_r);
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_deg(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == ATAN_IW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    i_r <= i_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.c    = x_r;
  assign rsp.s    = y_r;
endmodule

>>> sv/mouse_look_direction_unit.sv
// mouse_look_direction_unit: top level, sequencer around a shared
// multiplier and CORDIC. Depends on mld_pkg, mld_mul, mld_cordic.
//
// Usage: each pointer sample arrives on the in_ channel (valid/ready).
// The sample is turned into pixel deltas, scaled by the sensitivity and
// folded into yaw (wrapped to +-180 degrees) and pitch (clamped to
// +-89 degrees). Front and target vectors plus the heading are then
// presented on the out_ channel (valid/ready) as one transfer.
// From acceptance to out_valid a sample takes two passes through the
// single multiplier, PIXEL_BITS - 4 restoring steps for the yaw wrap,
// two CORDIC passes (pitch, then yaw) and two more multiplier passes,
// four passes through the single multiplier in all. One sample is in
// flight at a time; in_ready is low from acceptance until the result
// has been taken, so no new sample is taken while one is in flight.
// With free look disabled samples are accepted and dropped without a
// result. A stalled receiver holds the result and the block takes no
// new sample. After reset the first sample only records the pointer
// position (zero deltas) but still gives a result. Configuration
// writes on cfg_ take effect at once.
module mouse_look_direction_unit #(
  parameter int CORDIC_STEPS = 16,
  parameter int PIXEL_BITS   = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] in_pointer_x,
  input  logic [PIXEL_BITS-1:0] in_pointer_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_front_x,
  output logic signed [15:0]    out_front_y,
  output logic signed [15:0]    out_front_z,
  output logic signed [23:0]    out_target_x,
  output logic signed [23:0]    out_target_y,
  output logic signed [23:0]    out_target_z,
  output logic signed [15:0]    out_heading,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [23:0]           cfg_wdata
);
  import mld_pkg::*;

  localparam int DW = PIXEL_BITS + 1;
  localparam int PW = DW + 17;
  localparam int SW = PW - 9;
  localparam int TW = SW + 2;
  localparam int K  = TW - 16;
  localparam int RW = TW + 1;
  localparam int KW = $clog2(K + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_ANG  = 4'd3;
  localparam logic [3:0] S_MOD  = 4'd4;
  localparam logic [3:0] S_WRAP = 4'd5;
  localparam logic [3:0] S_CP   = 4'd6;
  localparam logic [3:0] S_CY   = 4'd7;
  localparam logic [3:0] S_M1   = 4'd8;
  localparam logic [3:0] S_M2   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]            state_r, state_nxt;
  logic [15:0]           sens_r;
  logic                  free_r;
  logic signed [23:0]    posx_r, posy_r, posz_r;
  logic [PIXEL_BITS-1:0] prevx_r, prevy_r;
  logic                  first_r;
  logic signed [15:0]    yaw_r, pitch_r;
  logic signed [DW-1:0]  dx_r, dy_r;
  logic signed [SW-1:0]  sx_r, sy_r;
  logic [RW-1:0]         mod_r, mod_nxt;
  logic [KW-1:0]         k_r;
  logic signed [15:0]    ya_r;
  logic                  neg_r;
  q30_t                  cp_r, sp_r, cy_r, syw_r;
  logic signed [15:0]    fx_r, fy_r, fz_r;
  logic                  out_valid_r;
  logic signed [23:0]    tx_r, ty_r, tz_r;

  q30_t                  mul_a, mul_b;
  logic signed [63:0]    mul_p;
  cordic_req_t           creq;
  cordic_rsp_t           crsp;

  logic                  in_xfer;
  logic [PIXEL_BITS-1:0] basex, basey;
  logic signed [63:0]    prod_rnd;
  logic signed [SW-1:0]  scaled;
  logic signed [TW-1:0]  tsum, psum;
  logic [RW-1:0]         msub;
  logic signed [15:0]    yaw_new;
  q30_t                  cy_nx, sy_nx;

  mld_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  mld_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  function automatic logic signed [15:0] q60_q14(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [17:0] v;
    t = p + (64'sd1 <<< 45);
    v = t[63:46];
    if (v > 18'sd16384) return 16'sd16384;
    if (v < -18'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] q30_q14(input q30_t p);
    logic signed [32:0] t;
    logic signed [16:0] v;
    t = 33'(p) + 33'sd32768;
    v = t[32:16];
    if (v > 17'sd16384) return 16'sd16384;
    if (v < -17'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] tgt(input logic signed [23:0] pos,
                                             input logic signed [15:0] f);
    logic signed [16:0] r;
    logic signed [24:0] s;
    r = 17'(f) + 17'sd32;
    s = 25'(pos) + 25'(signed'(r[16:6]));
    if (s > 25'sd8388607) return 24'sd8388607;
    if (s < -25'sd8388608) return -24'sd8388608;
    return s[23:0];
  endfunction

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_xfer  = in_valid && in_ready;
  assign basex    = first_r ? in_pointer_x : prevx_r;
  assign basey    = first_r ? in_pointer_y : prevy_r;

  assign prod_rnd = mul_p + 64'sd256;
  assign scaled   = prod_rnd[PW-1:9];
  assign tsum     = TW'(yaw_r) + TW'(sx_r) + TW'(HALF_TURN);
  assign psum     = TW'(pitch_r) + TW'(scaled);
  assign msub     = RW'(FULL_TURN) << k_r;
  assign mod_nxt  = (mod_r >= msub) ? (mod_r - msub) : mod_r;
  assign yaw_new  = signed'(mod_r[15:0]) - 16'(HALF_TURN);
  assign cy_nx    = neg_r ? -crsp.c : crsp.c;
  assign sy_nx    = neg_r ? -crsp.s : crsp.s;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MX: begin
        mul_a = 32'(dx_r);
        mul_b = 32'(sens_r);
      end
      S_MY: begin
        mul_a = 32'(dy_r);
        mul_b = 32'(sens_r);
      end
      S_M1: begin
        mul_a = cp_r;
        mul_b = cy_r;
      end
      S_M2: begin
        mul_a = cp_r;
        mul_b = syw_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    creq.start = 1'b0;
    creq.angle = pitch_r;
    if (state_r == S_WRAP) begin
      creq.start = 1'b1;
    end else if (state_r == S_CP && crsp.done) begin
      creq.start = 1'b1;
      creq.angle = ya_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer && free_r) state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_ANG;
      S_ANG:  state_nxt = S_MOD;
      S_MOD:  if (k_r == '0) state_nxt = S_WRAP;
      S_WRAP: state_nxt = S_CP;
      S_CP:   if (crsp.done) state_nxt = S_CY;
      S_CY:   if (crsp.done) state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sens_r      <= 16'd5243;
      free_r      <= 1'b1;
      posx_r      <= 24'sd256;
      posy_r      <= 24'sd25600;
      posz_r      <= 24'sd0;
      prevx_r     <= '0;
      prevy_r     <= '0;
      first_r     <= 1'b1;
      yaw_r       <= -16'sd11392;
      pitch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SENS: sens_r <= cfg_wdata[15:0];
          REG_FREE: free_r <= cfg_wdata[0];
          REG_POSX: posx_r <= cfg_wdata;
          REG_POSY: posy_r <= cfg_wdata;
          REG_POSZ: posz_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_xfer && free_r) begin
        prevx_r <= in_pointer_x;
        prevy_r <= in_pointer_y;
        first_r <= 1'b0;
      end
      if (state_r == S_ANG) begin
        if (psum > TW'(PITCH_LIMIT)) pitch_r <= 16'(PITCH_LIMIT);
        else if (psum < -TW'(PITCH_LIMIT)) pitch_r <= -16'(PITCH_LIMIT);
        else pitch_r <= psum[15:0];
      end
      if (state_r == S_WRAP) yaw_r <= yaw_new;
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
    if (in_xfer) begin
      dx_r <= DW'(in_pointer_x) - DW'(basex);
      dy_r <= DW'(basey) - DW'(in_pointer_y);
    end
    if (state_r == S_MY) sx_r <= scaled;
    if (state_r == S_ANG) begin
      mod_r <= {tsum[TW-1], tsum} + (RW'(FULL_TURN) << K);
      k_r   <= KW'(K);
    end
    if (state_r == S_MOD) begin
      mod_r <= mod_nxt;
      if (k_r != '0) k_r <= k_r - 1'b1;
    end
    if (state_r == S_WRAP) begin
      neg_r <= 1'b0;
      ya_r  <= yaw_new;
      if (yaw_new > 16'(QUARTER_TURN)) begin
        ya_r  <= yaw_new - 16'(HALF_TURN);
        neg_r <= 1'b1;
      end else if (yaw_new < -16'(QUARTER_TURN)) begin
        ya_r  <= yaw_new + 16'(HALF_TURN);
        neg_r <= 1'b1;
      end
    end
    if (state_r == S_CP && crsp.done) begin
      cp_r <= crsp.c;
      sp_r <= crsp.s;
    end
    if (state_r == S_CY && crsp.done) begin
      cy_r  <= cy_nx;
      syw_r <= sy_nx;
    end
    if (state_r == S_M2) begin
      fx_r <= q60_q14(mul_p);
      fy_r <= q30_q14(sp_r);
    end
    if (state_r == S_OUT) begin
      fz_r <= q60_q14(mul_p);
      tx_r <= tgt(posx_r, fx_r);
      ty_r <= tgt(posy_r, fy_r);
      tz_r <= tgt(posz_r, q60_q14(mul_p));
    end
  end

  assign out_valid    = out_valid_r;
  assign out_front_x  = fx_r;
  assign out_front_y  = fy_r;
  assign out_front_z  = fz_r;
  assign out_target_x = tx_r;
  assign out_target_y = ty_r;
  assign out_target_z = tz_r;
  assign out_heading  = yaw_r;
endmodule
